### rtl/core/kwre_pkg.sv
// Shared types, codes and character helpers for the k-mer window emitter.
`default_nettype none

package kwre_pkg;

  // Fixed field widths
  localparam int CHAR_W = 8;
  localparam int CFG_W  = 5;
  localparam int SEEN_W = 5;
  localparam int USER_W = 3;

  // Defaults
  localparam int WINDOW_MAX_DEF = 16;
  localparam logic [CFG_W-1:0]  KMER_LEN_RST = 5'd8;
  localparam logic [SEEN_W-1:0] SEEN_MAX     = 5'd31;

  // Characters
  localparam logic [CHAR_W-1:0] CH_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C  = 8'h43;
  localparam logic [CHAR_W-1:0] CH_G  = 8'h47;
  localparam logic [CHAR_W-1:0] CH_T  = 8'h54;
  localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

  // Group kind codes
  typedef enum logic [1:0] {
    KIND_FWD = 2'd0,
    KIND_RC  = 2'd1,
    KIND_RAW = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EMIT1 = 2'd1,
    ST_WRITE = 2'd2,
    ST_EMIT2 = 2'd3
  } seq_state_t;

  // Per-read tags that travel with the window read
  typedef struct packed {
    kind_t kind;
    logic  grp_end;
    logic  last;
  } rd_meta_t;

  function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CH_LA && c <= CH_LZ) begin
      r = c & ~CASE_BIT;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] complement(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    case (c)
      CH_A: r = CH_T;
      CH_T: r = CH_A;
      CH_G: r = CH_C;
      CH_C: r = CH_G;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/kwre_mem.sv
// Window character RAM: one write port, one registered read port.
`default_nettype none

module kwre_mem #(
  parameter int DEPTH = kwre_pkg::WINDOW_MAX_DEF,
  parameter int AW    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [kwre_pkg::CHAR_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [kwre_pkg::CHAR_W-1:0] rdata
);

  logic [kwre_pkg::CHAR_W-1:0] mem [DEPTH];
  logic [kwre_pkg::CHAR_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/kwre_seq.sv
// Sequencer: takes characters, walks the window RAM and issues reads per emitted char.
`default_nettype none

module kwre_seq #(
  parameter int WINDOW_MAX = kwre_pkg::WINDOW_MAX_DEF,
  parameter int AW = 4,
  parameter int LW = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [kwre_pkg::CHAR_W-1:0] in_tdata,
  input  wire logic                        in_tlast,
  input  wire logic [kwre_pkg::CFG_W-1:0]  kmer_len,
  output logic                             rd_valid,
  output logic      [AW-1:0]               rd_addr,
  output kwre_pkg::rd_meta_t               rd_meta,
  input  wire logic                        rd_go,
  output logic                             wr_en,
  output logic      [AW-1:0]               wr_addr,
  output logic      [kwre_pkg::CHAR_W-1:0] wr_data
);

  kwre_pkg::seq_state_t state_r, state_nxt;
  kwre_pkg::kind_t      kind_r, kind_nxt;
  logic [kwre_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic                        end_r, end_nxt;
  logic [kwre_pkg::SEEN_W-1:0] seen_r, seen_nxt;
  logic [kwre_pkg::SEEN_W-1:0] n1_r, n1_nxt;
  logic [LW-1:0]               k_r, k_nxt;
  logic [LW-1:0]               len_r, len_nxt;
  logic [LW-1:0]               idx_r, idx_nxt;
  logic [AW-1:0]               head_r, head_nxt;

  logic [LW-1:0]               k_eff;
  logic [kwre_pkg::SEEN_W-1:0] n1_in;
  logic [AW-1:0]               head_inc;
  logic [LW-1:0]               off;
  logic [LW:0]                 addr_wide;
  logic                        grp_end;
  logic                        accept;

  // Clamp the configured length into 1..WINDOW_MAX
  always_comb begin
    if (kmer_len == '0) begin
      k_eff = LW'(1);
    end else if (kmer_len > kwre_pkg::CFG_W'(WINDOW_MAX)) begin
      k_eff = LW'(WINDOW_MAX);
    end else begin
      k_eff = kmer_len[LW-1:0];
    end
  end

  assign n1_in    = (seen_r < kwre_pkg::SEEN_MAX) ? seen_r + 1'b1 : kwre_pkg::SEEN_MAX;
  assign head_inc = (head_r == AW'(WINDOW_MAX - 1)) ? '0 : head_r + 1'b1;
  assign accept   = in_tvalid && in_tready;
  assign grp_end  = (idx_r == len_r - 1'b1);

  // Circular address: forward and raw go oldest first, reverse goes newest first
  always_comb begin
    off = (kind_r == kwre_pkg::KIND_RC) ? idx_r : len_r - 1'b1 - idx_r;
    if ((LW + 1)'(head_r) >= (LW + 1)'(off)) begin
      addr_wide = (LW + 1)'(head_r) - (LW + 1)'(off);
    end else begin
      addr_wide = (LW + 1)'(head_r) + (LW + 1)'(WINDOW_MAX) - (LW + 1)'(off);
    end
  end

  assign rd_addr         = addr_wide[AW-1:0];
  assign rd_meta.kind    = kind_r;
  assign rd_meta.grp_end = grp_end;
  assign rd_meta.last    = grp_end && (kind_r != kwre_pkg::KIND_FWD) &&
                           ((state_r == kwre_pkg::ST_EMIT2) || !end_r);
  assign wr_addr         = head_inc;
  assign wr_data         = char_r;

  // Next state and outputs
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    char_nxt  = char_r;
    end_nxt   = end_r;
    seen_nxt  = seen_r;
    n1_nxt    = n1_r;
    k_nxt     = k_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    head_nxt  = head_r;
    in_tready = 1'b0;
    rd_valid  = 1'b0;
    wr_en     = 1'b0;
    case (state_r)
      kwre_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          char_nxt = in_tdata;
          end_nxt  = in_tlast;
          n1_nxt   = n1_in;
          k_nxt    = k_eff;
          len_nxt  = k_eff;
          idx_nxt  = '0;
          kind_nxt = kwre_pkg::KIND_FWD;
          seen_nxt = in_tlast ? '0 : n1_in;
          // k-mer ending on the previous char comes first
          state_nxt = (seen_r >= kwre_pkg::SEEN_W'(k_eff)) ? kwre_pkg::ST_EMIT1
                                                           : kwre_pkg::ST_WRITE;
        end
      end
      kwre_pkg::ST_EMIT1, kwre_pkg::ST_EMIT2: begin
        rd_valid = 1'b1;
        if (rd_go) begin
          if (grp_end) begin
            idx_nxt = '0;
            if (kind_r == kwre_pkg::KIND_FWD) begin
              kind_nxt = kwre_pkg::KIND_RC;
            end else begin
              state_nxt = (state_r == kwre_pkg::ST_EMIT1) ? kwre_pkg::ST_WRITE
                                                          : kwre_pkg::ST_IDLE;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      kwre_pkg::ST_WRITE: begin
        wr_en    = 1'b1;
        head_nxt = head_inc;
        idx_nxt  = '0;
        if (end_r) begin
          state_nxt = kwre_pkg::ST_EMIT2;
          if (n1_r > kwre_pkg::SEEN_W'(k_r)) begin
            kind_nxt = kwre_pkg::KIND_FWD;
            len_nxt  = k_r;
          end else begin
            // short sequence: n1 never exceeds k here
            kind_nxt = kwre_pkg::KIND_RAW;
            len_nxt  = n1_r[LW-1:0];
          end
        end else begin
          state_nxt = kwre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kwre_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kwre_pkg::ST_IDLE;
      seen_r  <= '0;
      head_r  <= '0;
      kind_r  <= kwre_pkg::KIND_FWD;
      idx_r   <= '0;
      len_r   <= LW'(1);
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      head_r  <= head_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
    end
  end

  // Captured item
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    end_r  <= end_nxt;
    n1_r   <= n1_nxt;
    k_r    <= k_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/kwre_out.sv
// Read pipeline tail: tags the RAM data, applies case and complement, holds the result.
`default_nettype none

module kwre_out (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_valid,
  input  wire kwre_pkg::rd_meta_t           rd_meta,
  output logic                              rd_go,
  input  wire logic [kwre_pkg::CHAR_W-1:0]  rd_data,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [kwre_pkg::CHAR_W-1:0]  out_tdata,
  output logic                              out_tlast,
  output logic      [kwre_pkg::USER_W-1:0]  out_tuser
);

  logic                        pend_r, pend_nxt;
  kwre_pkg::rd_meta_t          meta_r;
  logic                        oval_r, oval_nxt;
  logic [kwre_pkg::CHAR_W-1:0] odata_r;
  logic [kwre_pkg::CHAR_W-1:0] xchar;
  kwre_pkg::kind_t             okind_r;
  logic                        oend_r;
  logic                        olast_r;
  logic                        take;

  // RAM data moves on when the output slot is free or draining
  assign take  = pend_r && (!oval_r || out_tready);
  assign rd_go = rd_valid && (!pend_r || take);

  always_comb begin
    pend_nxt = pend_r;
    if (rd_go) begin
      pend_nxt = 1'b1;
    end else if (take) begin
      pend_nxt = 1'b0;
    end
    oval_nxt = oval_r;
    if (take) begin
      oval_nxt = 1'b1;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end
  end

  // Character transform by group kind
  always_comb begin
    case (meta_r.kind)
      kwre_pkg::KIND_FWD: xchar = kwre_pkg::to_upper(rd_data);
      kwre_pkg::KIND_RC:  xchar = kwre_pkg::complement(kwre_pkg::to_upper(rd_data));
      default:            xchar = rd_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      meta_r <= rd_meta;
    end
    if (take) begin
      odata_r <= xchar;
      okind_r <= meta_r.kind;
      oend_r  <= meta_r.grp_end;
      olast_r <= meta_r.last;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = oend_r;
  assign out_tuser  = {olast_r, okind_r};

endmodule

`default_nettype wire

### rtl/core/kmer_window_revcomp_emitter_unit.sv
// Top level of the k-mer window emitter with reverse complement.
`default_nettype none

// Takes one character per input transaction (in_tlast marks the end of a sequence) and
// emits characters one per output transaction. Once a sequence holds more than k chars,
// each new char releases the k-mer ending on the char before it, forward upper-cased and
// then reverse complemented; the final char also releases the k-mer ending on itself.
// A sequence no longer than k comes out raw at its end. Each item also takes an accept
// and a window write; no new char is taken until it is done. The single read port of
// the window RAM gives one char per cycle unless the output stalls. The user must
// write kmer_len only while the block is idle; the block does not enforce it. 0 acts as
// 1, values above WINDOW_MAX act as WINDOW_MAX. The RAM needs no clearing after reset.
module kmer_window_revcomp_emitter_unit #(
  parameter int WINDOW_MAX = kwre_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // in_tdata: [7:0] in_char
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [kwre_pkg::CHAR_W-1:0] in_tdata,
  input  wire logic                        in_tlast,
  // out_tdata: [7:0] out_char
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [kwre_pkg::CHAR_W-1:0] out_tdata,
  output logic                             out_tlast,
  // out_tuser: [1:0] group_kind, [2] last_result
  output logic      [kwre_pkg::USER_W-1:0] out_tuser,
  input  wire logic                        cfg_wr_en,
  input  wire logic [kwre_pkg::CFG_W-1:0]  cfg_wr_data
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LW = $clog2(WINDOW_MAX + 1);

  logic [kwre_pkg::CFG_W-1:0]  kmer_len_r;
  logic                        rd_valid;
  logic [AW-1:0]               rd_addr;
  kwre_pkg::rd_meta_t          rd_meta;
  logic                        rd_go;
  logic [kwre_pkg::CHAR_W-1:0] rd_data;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [kwre_pkg::CHAR_W-1:0] wr_data;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= kwre_pkg::KMER_LEN_RST;
    end else if (cfg_wr_en) begin
      kmer_len_r <= cfg_wr_data;
    end
  end

  kwre_seq #(
    .WINDOW_MAX (WINDOW_MAX),
    .AW         (AW),
    .LW         (LW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .kmer_len  (kmer_len_r),
    .rd_valid  (rd_valid),
    .rd_addr   (rd_addr),
    .rd_meta   (rd_meta),
    .rd_go     (rd_go),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  kwre_mem #(
    .DEPTH (WINDOW_MAX),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_go),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  kwre_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_valid   (rd_valid),
    .rd_meta    (rd_meta),
    .rd_go      (rd_go),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // A window write never shares a cycle with a window read
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_go))
    else $error("window read and write in the same cycle");

  // The final result of an item always closes a group
  a_last_closes_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast)
    else $error("last result without group end");

  // An accepted character always occupies the sequencer for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after acceptance");

  // Raw groups are never reverse complemented, so kind code 3 never shows
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1:0] != 2'd3))
    else $error("illegal group kind on output");

endmodule

`default_nettype wire
